FILE: src/cre_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cre_pkg
// Shared types and constants of the chunked escape-byte run-length expander.
// ---------------------------------------------------------------------------
package cre_pkg;

    localparam int BEAT_BYTES_DEF = 8;
    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 4;
    localparam int TOTAL_W        = 32;
    localparam int CHUNK_W        = 16;

    typedef enum logic [3:0] {
        PH_TOT0   = 4'd0,
        PH_TOT1   = 4'd1,
        PH_TOT2   = 4'd2,
        PH_TOT3   = 4'd3,
        PH_CLO    = 4'd4,
        PH_CHI    = 4'd5,
        PH_PREFIX = 4'd6,
        PH_BYTE   = 4'd7,
        PH_COUNT  = 4'd8,
        PH_VALUE  = 4'd9,
        PH_DONE   = 4'd10
    } t_phase;

    typedef struct packed {
        logic              load;
        logic              zero_only;
        logic              done;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] value;
    } t_job;

endpackage

FILE: src/cre_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cre_if
// Valid/ready channels: compressed byte in, expanded beat out.
// ---------------------------------------------------------------------------
interface cre_in_if;
    logic                      valid;
    logic                      ready;
    logic [cre_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cre_out_if;
    logic                       valid;
    logic                       ready;
    logic [cre_pkg::BYTE_W-1:0] out_b0;
    logic [cre_pkg::BYTE_W-1:0] out_b1;
    logic [cre_pkg::BYTE_W-1:0] out_b2;
    logic [cre_pkg::BYTE_W-1:0] out_b3;
    logic [cre_pkg::BYTE_W-1:0] out_b4;
    logic [cre_pkg::BYTE_W-1:0] out_b5;
    logic [cre_pkg::BYTE_W-1:0] out_b6;
    logic [cre_pkg::BYTE_W-1:0] out_b7;
    logic [cre_pkg::CNT_W-1:0]  byte_count;
    logic                       last_beat;
    logic                       stream_done;

    modport source (output valid, output out_b0, output out_b1, output out_b2,
                    output out_b3, output out_b4, output out_b5, output out_b6,
                    output out_b7, output byte_count, output last_beat,
                    output stream_done, input ready);
    modport sink   (input valid, input out_b0, input out_b1, input out_b2,
                    input out_b3, input out_b4, input out_b5, input out_b6,
                    input out_b7, input byte_count, input last_beat,
                    input stream_done, output ready);
endinterface

FILE: src/chunked_rle_escape_expander_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chunked_rle_escape_expander_top
// Chunked escape-byte run-length expander: headers, literals and runs in,
// expanded bytes out in beats.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one compressed byte per item; o_out carries one beat of up
//   to BEAT_BYTES expanded bytes, byte_count valid, last_beat on the final
//   beat caused by an input item, stream_done once the total is exhausted.
//   A header or escape byte gives no beat, unless it ends the stream with an
//   empty done beat. An item that expands to N bytes keeps i_in.ready low
//   for ceil(N / BEAT_BYTES) beat steps of the shared subtractor in the beat
//   generator, one beat a cycle while the output stage can advance; the job
//   is registered first and each beat is then registered in the output stage.
//   The output stage is a register: while it holds a beat the next item is
//   still taken if no steps remain. A stalled receiver holds the beat and
//   freezes the beat generator, which keeps i_in.ready low while steps remain.
//   Reset (synchronous, active low) returns to the first total size byte and
//   clears the counters and the output stage's valid flag; no clearing pass.
//   Once done, every byte is accepted and dropped.
// ---------------------------------------------------------------------------
module chunked_rle_escape_expander_top #(
    parameter int BEAT_BYTES = cre_pkg::BEAT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cre_in_if.sink     i_in,
    cre_out_if.source  o_out
);

    cre_pkg::t_phase              r_phase, n_phase;
    logic [cre_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [cre_pkg::CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [cre_pkg::BYTE_W-1:0]   r_esc, n_esc;
    logic [cre_pkg::BYTE_W-1:0]   r_run, n_run;
    cre_pkg::t_job                job;
    logic                         gen_idle;
    logic                         accept;
    logic [cre_pkg::BYTE_W-1:0]   b;
    logic [cre_pkg::BYTE_W-1:0]   n_len;
    logic [cre_pkg::BYTE_W-1:0]   v;
    logic [cre_pkg::TOTAL_W:0]    tot_diff;
    logic [cre_pkg::CHUNK_W:0]    chk_diff;
    logic [cre_pkg::TOTAL_W-1:0]  tot_sat;
    logic [cre_pkg::CHUNK_W-1:0]  chk_sat;

    function automatic cre_pkg::t_phase boundary(
        input logic [cre_pkg::CHUNK_W-1:0] chunk,
        input logic [cre_pkg::TOTAL_W-1:0] total
    );
        cre_pkg::t_phase ph;
        if (chunk != '0) begin
            ph = cre_pkg::PH_BYTE;
        end else if (total == '0) begin
            ph = cre_pkg::PH_DONE;
        end else begin
            ph = cre_pkg::PH_CLO;
        end
        return ph;
    endfunction

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = gen_idle;
    assign b          = i_in.in_byte;

    assign tot_diff = {1'b0, r_total} - (cre_pkg::TOTAL_W + 1)'(n_len);
    assign chk_diff = {1'b0, r_chunk} - (cre_pkg::CHUNK_W + 1)'(n_len);
    assign tot_sat  = tot_diff[cre_pkg::TOTAL_W] ? '0 : tot_diff[cre_pkg::TOTAL_W-1:0];
    assign chk_sat  = chk_diff[cre_pkg::CHUNK_W] ? '0 : chk_diff[cre_pkg::CHUNK_W-1:0];

    always_comb begin
        n_len = '0;
        v     = '0;
        if ((r_phase == cre_pkg::PH_BYTE) && (b != r_esc)) begin
            v     = b;
            n_len = 8'd1;
        end else if (r_phase == cre_pkg::PH_VALUE) begin
            v     = b;
            n_len = r_run;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        n_chunk = r_chunk;
        n_esc   = r_esc;
        n_run   = r_run;
        unique case (r_phase)
            cre_pkg::PH_TOT0: begin
                n_total = {24'd0, b};
                n_phase = cre_pkg::PH_TOT1;
            end
            cre_pkg::PH_TOT1: begin
                n_total[15:8] = b;
                n_phase       = cre_pkg::PH_TOT2;
            end
            cre_pkg::PH_TOT2: begin
                n_total[23:16] = b;
                n_phase        = cre_pkg::PH_TOT3;
            end
            cre_pkg::PH_TOT3: begin
                n_total[31:24] = b;
                n_phase = ({b, r_total[23:0]} == '0) ? cre_pkg::PH_DONE : cre_pkg::PH_CLO;
            end
            cre_pkg::PH_CLO: begin
                n_chunk = {8'd0, b};
                n_phase = cre_pkg::PH_CHI;
            end
            cre_pkg::PH_CHI: begin
                n_chunk[15:8] = b;
                n_phase       = cre_pkg::PH_PREFIX;
            end
            cre_pkg::PH_PREFIX: begin
                n_esc   = b;
                n_phase = boundary(r_chunk, r_total);
            end
            cre_pkg::PH_BYTE: begin
                if (b == r_esc) begin
                    n_phase = cre_pkg::PH_COUNT;
                end
            end
            cre_pkg::PH_COUNT: begin
                n_run   = b;
                n_phase = cre_pkg::PH_VALUE;
            end
            cre_pkg::PH_VALUE: begin
                if (r_run == '0) begin
                    n_phase = boundary(r_chunk, r_total);
                end
            end
            default: begin
            end
        endcase
        if (n_len != '0) begin
            n_total = tot_sat;
            n_chunk = chk_sat;
            n_phase = boundary(chk_sat, tot_sat);
        end
    end

    always_comb begin
        job.load      = accept && ((n_len != '0) ||
                        ((r_phase != cre_pkg::PH_DONE) && (n_phase == cre_pkg::PH_DONE)));
        job.zero_only = (n_len == '0);
        job.done      = (n_phase == cre_pkg::PH_DONE);
        job.count     = n_len;
        job.value     = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cre_pkg::PH_TOT0;
            r_total <= '0;
            r_chunk <= '0;
            r_esc   <= '0;
            r_run   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_total <= n_total;
            r_chunk <= n_chunk;
            r_esc   <= n_esc;
            r_run   <= n_run;
        end
    end

    cre_beat_gen #(
        .BEAT_BYTES (BEAT_BYTES)
    ) u_beat_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_idle  (gen_idle),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == cre_pkg::PH_DONE)) |-> !job.load)
        else $error("item after end of stream produced output");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cre_pkg::PH_DONE) |=> (r_phase == cre_pkg::PH_DONE))
        else $error("left the done phase");
    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_done) |-> (r_phase == cre_pkg::PH_DONE))
        else $error("done beat while stream still open");
`endif

endmodule

FILE: src/cre_beat_gen.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cre_beat_gen
// Splits one expansion job into beats of up to BEAT_BYTES bytes, one beat
// per step of a shared subtractor, into a registered output stage.
// ---------------------------------------------------------------------------
module cre_beat_gen #(
    parameter int BEAT_BYTES = cre_pkg::BEAT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cre_pkg::t_job     i_job,
    output logic              o_idle,
    cre_out_if.source         o_out
);

    localparam logic [cre_pkg::BYTE_W:0]  BEAT_W9 = (cre_pkg::BYTE_W + 1)'(BEAT_BYTES);
    localparam logic [cre_pkg::CNT_W-1:0] BEAT_C  = cre_pkg::CNT_W'(BEAT_BYTES);

    logic [cre_pkg::BYTE_W-1:0] r_rem, n_rem;
    logic [cre_pkg::BYTE_W-1:0] r_val, n_val;
    logic                       r_done, n_done;
    logic                       r_zero, n_zero;
    logic                       r_ovalid, n_ovalid;
    logic [cre_pkg::BYTE_W-1:0] r_obyte, n_obyte;
    logic [cre_pkg::CNT_W-1:0]  r_ocnt, n_ocnt;
    logic                       r_olast, n_olast;
    logic                       r_odone, n_odone;
    logic [cre_pkg::BYTE_W:0]   diff;
    logic [cre_pkg::BYTE_W-1:0] rem_sat;
    logic [cre_pkg::CNT_W-1:0]  beat_cnt;
    logic                       adv;
    logic [cre_pkg::BYTE_W-1:0] ob [8];

    assign diff     = {1'b0, r_rem} - BEAT_W9;
    assign rem_sat  = diff[cre_pkg::BYTE_W] ? '0 : diff[cre_pkg::BYTE_W-1:0];
    assign beat_cnt = diff[cre_pkg::BYTE_W] ? r_rem[cre_pkg::CNT_W-1:0] : BEAT_C;
    assign adv      = !r_ovalid || o_out.ready;
    assign o_idle   = (r_rem == '0) && !r_zero;

    always_comb begin
        n_rem    = r_rem;
        n_val    = r_val;
        n_done   = r_done;
        n_zero   = r_zero;
        n_ovalid = r_ovalid && !o_out.ready;
        n_obyte  = r_obyte;
        n_ocnt   = r_ocnt;
        n_olast  = r_olast;
        n_odone  = r_odone;
        if (i_job.load) begin
            n_rem  = i_job.count;
            n_val  = i_job.value;
            n_done = i_job.done;
            n_zero = i_job.zero_only;
        end else if (adv && (r_rem != '0)) begin
            n_rem    = rem_sat;
            n_ovalid = 1'b1;
            n_obyte  = r_val;
            n_ocnt   = beat_cnt;
            n_olast  = (rem_sat == '0);
            n_odone  = r_done;
        end else if (adv && r_zero) begin
            n_zero   = 1'b0;
            n_ovalid = 1'b1;
            n_obyte  = '0;
            n_ocnt   = '0;
            n_olast  = 1'b1;
            n_odone  = r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_zero   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rem    <= n_rem;
            r_zero   <= n_zero;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_done  <= n_done;
        r_obyte <= n_obyte;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            ob[j] = (cre_pkg::CNT_W'(j) < r_ocnt) ? r_obyte : '0;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_b0      = ob[0];
    assign o_out.out_b1      = ob[1];
    assign o_out.out_b2      = ob[2];
    assign o_out.out_b3      = ob[3];
    assign o_out.out_b4      = ob[4];
    assign o_out.out_b5      = ob[5];
    assign o_out.out_b6      = ob[6];
    assign o_out.out_b7      = ob[7];
    assign o_out.byte_count  = r_ocnt;
    assign o_out.last_beat   = r_olast;
    assign o_out.stream_done = r_odone;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ocnt <= BEAT_C))
        else $error("beat wider than BEAT_BYTES");
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ocnt == '0)) |-> (r_olast && r_odone))
        else $error("empty beat that does not end the stream");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.load |-> o_idle)
        else $error("job loaded while a job is in progress");
`endif

endmodule

FILE: bench/expansion_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// expansion_checker
// Watches both channels of the escape-byte run-length expander. Every byte
// taken on the input is run through a local model of the decoder; the beats
// it should produce are queued and each beat taken on the output is checked
// field by field against the oldest one.
// ---------------------------------------------------------------------------
module expansion_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cre_in_if    i_in_mon,
    cre_out_if   i_out_mon,
    output int   o_error_count,
    output int   o_beats_pending
);
    import cre_pkg::*;

    localparam int BEAT = BEAT_BYTES_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]       count;
        logic                   last;
        logic                   done;
    } t_beat;

    t_phase              ph;
    logic [TOTAL_W-1:0]  total_left;
    logic [CHUNK_W-1:0]  chunk_left;
    logic [BYTE_W-1:0]   escape_byte;
    logic [BYTE_W-1:0]   run_len;
    t_beat               expected_beats[$];
    int                  mismatches;

    initial begin
        mismatches      = 0;
        o_error_count   = 0;
        o_beats_pending = 0;
    end

    function automatic t_phase symbol_end_phase();
        if (chunk_left != 0) return PH_BYTE;
        if (total_left == 0) return PH_DONE;
        return PH_CLO;
    endfunction

    task automatic expand_byte(input logic [BYTE_W-1:0] b);
        int                n;
        int                left;
        int                cnt;
        logic [BYTE_W-1:0] v;
        logic              was_done;
        t_beat             beat;
        n        = 0;
        v        = '0;
        was_done = (ph == PH_DONE);
        case (ph)
            PH_TOT0: begin
                total_left = {24'd0, b};
                ph = PH_TOT1;
            end
            PH_TOT1: begin
                total_left[15:8] = b;
                ph = PH_TOT2;
            end
            PH_TOT2: begin
                total_left[23:16] = b;
                ph = PH_TOT3;
            end
            PH_TOT3: begin
                total_left[31:24] = b;
                ph = (total_left == 0) ? PH_DONE : PH_CLO;
            end
            PH_CLO: begin
                chunk_left = {8'd0, b};
                ph = PH_CHI;
            end
            PH_CHI: begin
                chunk_left[15:8] = b;
                ph = PH_PREFIX;
            end
            PH_PREFIX: begin
                escape_byte = b;
                ph = symbol_end_phase();
            end
            PH_BYTE: begin
                if (b == escape_byte) begin
                    ph = PH_COUNT;
                end else begin
                    v = b;
                    n = 1;
                end
            end
            PH_COUNT: begin
                run_len = b;
                ph = PH_VALUE;
            end
            PH_VALUE: begin
                v = b;
                n = run_len;
                if (n == 0) ph = symbol_end_phase();
            end
            default: ;
        endcase

        if (n == 0) begin
            if (!was_done && ph == PH_DONE) begin
                beat = '0;
                beat.last = 1'b1;
                beat.done = 1'b1;
                expected_beats.push_back(beat);
            end
        end else begin
            // counters stop at zero; the run itself is never cut short
            chunk_left = (chunk_left > n) ? CHUNK_W'(chunk_left - n) : '0;
            total_left = (total_left > n) ? TOTAL_W'(total_left - n) : '0;
            ph = symbol_end_phase();
            left = n;
            while (left > 0) begin
                cnt = (left < BEAT) ? left : BEAT;
                beat = '0;
                for (int j = 0; j < cnt; j++) beat.bytes[j] = v;
                beat.count = CNT_W'(cnt);
                beat.last  = (left <= BEAT);
                beat.done  = (ph == PH_DONE);
                expected_beats.push_back(beat);
                left -= cnt;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_beat got;
        t_beat want;
        logic  bad;
        if (!i_rst_n) begin
            ph          = PH_TOT0;
            total_left  = '0;
            chunk_left  = '0;
            escape_byte = '0;
            run_len     = '0;
            expected_beats.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.bytes = {i_out_mon.out_b7, i_out_mon.out_b6, i_out_mon.out_b5,
                             i_out_mon.out_b4, i_out_mon.out_b3, i_out_mon.out_b2,
                             i_out_mon.out_b1, i_out_mon.out_b0};
                got.count = i_out_mon.byte_count;
                got.last  = i_out_mon.last_beat;
                got.done  = i_out_mon.stream_done;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected beat bytes=%h count=%0d last=%b done=%b",
                                 $time, got.bytes, got.count, got.last, got.done);
                end else begin
                    want = expected_beats.pop_front();
                    bad = (got.count !== want.count) || (got.last !== want.last) ||
                          (got.done !== want.done);
                    for (int j = 0; j < 8; j++)
                        if (got.bytes[j] !== want.bytes[j]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: beat mismatch, expected bytes=%h count=%0d last=%b done=%b",
                                     $time, want.bytes, want.count, want.last, want.done);
                            $display("%0t:                got bytes=%h count=%0d last=%b done=%b",
                                     $time, got.bytes, got.count, got.last, got.done);
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) expand_byte(i_in_mon.in_byte);
        end
        o_error_count   <= mismatches;
        o_beats_pending <= expected_beats.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Feeds one compressed stream to the escape-byte run-length expander: a
// total size header, directed chunks with literals and runs of edge lengths,
// then random chunks and symbols, then mostly runs that exhaust the total and bytes
// that must be dropped once the stream is done. Sender gaps and receiver
// stalls vary by stage; the checker beside the block does the comparison.
// ---------------------------------------------------------------------------
module testbench;
    import cre_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int BODY_ITEMS     = 250;
    localparam int PAUSE_AT       = 140;
    localparam int TOTAL_RESERVE  = 700;
    localparam int HEAVY_PCT      = 78;
    localparam int LIGHT_PCT      = 14;
    localparam int SETTLE_CYCLES  = 40;
    localparam int IGNORED_ITEMS  = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic clk = 1'b0;
    logic rst_n;
    int   error_count;
    int   beats_pending;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   stall_pct;

    logic [TOTAL_W-1:0] str_total;
    logic [CHUNK_W-1:0] str_chunk;
    logic [BYTE_W-1:0]  str_escape;
    logic               str_done;
    logic               str_need_header;

    cre_in_if  in_if ();
    cre_out_if out_if ();

    chunked_rle_escape_expander_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    expansion_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_mon        (in_if),
        .i_out_mon       (out_if),
        .o_error_count   (error_count),
        .o_beats_pending (beats_pending)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_pct == 0) out_if.ready <= 1'b1;
        else out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_idle mode;
        int    gap;
        mode = (items_sent < 240) ? t_idle'(items_sent / 60)
                                  : t_idle'((items_sent / 40) % 4);
        case (mode)
            IDLE_SENDER: begin
                gap = HEAVY_PCT;
                stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                gap = 0;
                stall_pct <= HEAVY_PCT;
            end
            IDLE_BOTH: begin
                gap = LIGHT_PCT;
                stall_pct <= LIGHT_PCT;
            end
            default: begin
                gap = 0;
                stall_pct <= 0;
            end
        endcase
        if (gap != 0 && $urandom_range(99) < gap) begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge clk); while (!in_if.ready);
        items_sent++;
    endtask

    // track what the stream has left so it can be steered to a clean end
    task automatic account_bytes(input int n);
        if (n > 0) begin
            str_chunk = (str_chunk > n) ? CHUNK_W'(str_chunk - n) : '0;
            str_total = (str_total > n) ? TOTAL_W'(str_total - n) : '0;
        end
        str_need_header = 1'b0;
        if (str_chunk == 0) begin
            if (str_total == 0) str_done = 1'b1;
            else str_need_header = 1'b1;
        end
    endtask

    task automatic send_chunk(input logic [CHUNK_W-1:0] size, input logic [BYTE_W-1:0] prefix);
        push_byte(size[7:0]);
        push_byte(size[15:8]);
        push_byte(prefix);
        str_chunk  = size;
        str_escape = prefix;
        account_bytes(0);
    endtask

    task automatic send_literal(input logic [BYTE_W-1:0] b);
        push_byte(b);
        account_bytes(1);
    endtask

    task automatic send_run(input int cnt, input logic [BYTE_W-1:0] val);
        push_byte(str_escape);
        push_byte(BYTE_W'(cnt));
        push_byte(val);
        account_bytes(cnt);
    endtask

    function automatic logic [BYTE_W-1:0] pick_literal();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255)); while (b == str_escape);
        return b;
    endfunction

    initial begin
        logic [BYTE_W-1:0]  total_lo;
        logic [CHUNK_W-1:0] size;
        logic [BYTE_W-1:0]  val;
        logic               paused;
        int                 roll;
        int                 cnt;

        rst_n         = 1'b0;
        stall_pct     = 0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;
        paused        = 1'b0;
        str_done      = 1'b0;
        str_chunk     = '0;
        str_escape    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        total_lo = BYTE_W'($urandom_range(255));
        push_byte(total_lo);
        push_byte(8'h0C);
        push_byte(8'h00);
        push_byte(8'h00);
        str_total       = {16'd0, 8'h0C, total_lo};
        str_need_header = 1'b1;

        // empty chunk, then a 255-byte chunk overrun by a full-length run
        send_chunk(16'd0, 8'hFF);
        send_chunk(16'd255, 8'h00);
        send_literal(8'hFF);
        send_literal(8'h01);
        send_run(0, 8'h55);
        send_run(1, 8'h00);
        send_run(8, 8'hA5);
        send_run(9, 8'h5A);
        send_run(255, 8'hFF);

        while (!str_done) begin
            if (str_need_header) begin
                roll = $urandom_range(99);
                if (roll < 8) size = '0;
                else if (roll < 75) size = CHUNK_W'($urandom_range(64, 1));
                else if (roll < 95) size = CHUNK_W'($urandom_range(400, 65));
                else size = CHUNK_W'($urandom_range(2000, 401));
                send_chunk(size, BYTE_W'($urandom_range(255)));
            end else if (items_sent < BODY_ITEMS && str_total > TOTAL_RESERVE) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    send_literal(pick_literal());
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 10) cnt = 0;
                    else if (roll < 65) cnt = $urandom_range(16, 1);
                    else if (roll < 85) cnt = $urandom_range(64, 17);
                    else cnt = $urandom_range(255, 65);
                    val = ($urandom_range(4) == 0) ? str_escape : BYTE_W'($urandom_range(255));
                    send_run(cnt, val);
                end
            end else begin
                // exhaust the total, mostly with full-length runs
                if ($urandom_range(9) == 0) begin
                    send_literal(pick_literal());
                end else begin
                    cnt = ($urandom_range(3) == 0) ? $urandom_range(254, 1) : 255;
                    send_run(cnt, BYTE_W'($urandom_range(255)));
                end
            end
            if (!paused && items_sent >= PAUSE_AT) begin
                in_if.valid <= 1'b0;
                @(posedge clk);
                while (beats_pending != 0) @(posedge clk);
                paused = 1'b1;
            end
        end

        repeat (IGNORED_ITEMS) push_byte(BYTE_W'($urandom_range(255)));
        in_if.valid <= 1'b0;

        @(posedge clk);
        while (beats_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && beats_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
